// ----- design/llhs_pkg.sv -----
// ----------------------------------------------------------------------------
// llhs_pkg
// Shared types and constants for the lane line history smoother.
// ----------------------------------------------------------------------------
package llhs_pkg;

  // Field widths
  localparam int RHO_W     = 16;
  localparam int THETA_W   = 15;
  localparam int ENTRY_W   = RHO_W + THETA_W;
  localparam int DEPTH_W   = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  // History capacity defaults
  localparam int MAX_HISTORY = 16;
  localparam int DEPTH_RESET = 10;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Angle windows, Q2.13 radians
  localparam logic [THETA_W-1:0] THETA_LEFT_MAX  = 15'd8578;
  localparam logic [THETA_W-1:0] THETA_RIGHT_MIN = 15'd17158;
  localparam logic [THETA_W-1:0] THETA_PI        = 15'd25736;

  // Side index
  localparam int SIDE_LEFT  = 0;
  localparam int SIDE_RIGHT = 1;

  // One classified item: per side push or drop, plus frame close
  typedef struct packed {
    logic [1:0]                push;
    logic [1:0]                drop;
    logic                      frame_end;
    logic signed [RHO_W-1:0]   rho;
    logic [THETA_W-1:0]        theta;
  } cmd_t;

endpackage

// ----- design/llhs_ram.sv -----
// ----------------------------------------------------------------------------
// llhs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module llhs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/llhs_div.sv -----
// ----------------------------------------------------------------------------
// llhs_div
// Bit-serial restoring divider: unsigned dividend by a narrow unsigned
// divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module llhs_div #(
  parameter int DividendW = 20,
  parameter int DivisorW  = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int StepW = $clog2(DividendW + 1);

  logic                 busy_q;
  logic [StepW-1:0]     step_q;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    logic [DivisorW:0] trial;
    trial = {rem_q, quo_q[DividendW-1]};
    quo_d = {quo_q[DividendW-2:0], 1'b0};
    rem_d = trial[DivisorW-1:0];
    if (trial >= {1'b0, dvs_q}) begin
      rem_d    = DivisorW'(trial - {1'b0, dvs_q});
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(DividendW);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/llhs_fifo.sv -----
// ----------------------------------------------------------------------------
// llhs_fifo
// Small command queue between the classifying front and the history back.
// ----------------------------------------------------------------------------
module llhs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  llhs_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output llhs_pkg::cmd_t pop_data_o
);
  import llhs_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = (fill_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

endmodule

// ----- design/llhs_front.sv -----
// ----------------------------------------------------------------------------
// llhs_front
// Input side: takes line beats, picks the first left and first right line
// of each frame and turns every beat into a history command.
// ----------------------------------------------------------------------------
module llhs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [llhs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                        s_axis_tlast,
  input  logic                        s_axis_tuser,
  input  logic                        queue_full_i,
  output logic                        cmd_push_o,
  output llhs_pkg::cmd_t              cmd_o
);
  import llhs_pkg::*;

  logic                     found_l_q, found_r_q;
  logic                     accept;
  logic signed [RHO_W-1:0]  rho;
  logic [THETA_W-1:0]       theta;
  logic                     push_l, push_r;

  assign s_axis_tready = !queue_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rho   = s_axis_tdata[RHO_W-1:0];
  assign theta = s_axis_tdata[RHO_W +: THETA_W];

  // classify: left window wins, right only if left did not take it
  always_comb begin
    push_l = s_axis_tuser && !found_l_q && (theta <= THETA_LEFT_MAX);
    push_r = s_axis_tuser && !found_r_q && !push_l &&
             (theta >= THETA_RIGHT_MIN) && (theta <= THETA_PI);
  end

  // build the command
  always_comb begin
    cmd_o                  = '0;
    cmd_o.push[SIDE_LEFT]  = push_l;
    cmd_o.push[SIDE_RIGHT] = push_r;
    cmd_o.drop[SIDE_LEFT]  = s_axis_tlast && !(found_l_q || push_l);
    cmd_o.drop[SIDE_RIGHT] = s_axis_tlast && !(found_r_q || push_r);
    cmd_o.frame_end        = s_axis_tlast;
    cmd_o.rho              = rho;
    cmd_o.theta            = theta;
  end

  assign cmd_push_o = accept;

  // per frame found flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_l_q <= 1'b0;
      found_r_q <= 1'b0;
    end else if (accept) begin
      found_l_q <= !s_axis_tlast && (found_l_q || push_l);
      found_r_q <= !s_axis_tlast && (found_r_q || push_r);
    end
  end

endmodule

// ----- design/llhs_back.sv -----
// ----------------------------------------------------------------------------
// llhs_back
// History side: keeps both rings, counts and running sums, trims on a depth
// change and produces the averaged result at frame end.
// ----------------------------------------------------------------------------
module llhs_back #(
  parameter int MaxHistory = llhs_pkg::MAX_HISTORY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [llhs_pkg::DEPTH_W-1:0]  cfg_wdata_i,
  input  logic                          cmd_valid_i,
  input  llhs_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [llhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser
);
  import llhs_pkg::*;

  localparam int CntW     = $clog2(MaxHistory + 1);
  localparam int IdxW     = (MaxHistory > 1) ? $clog2(MaxHistory) : 1;
  localparam int SlotW    = CntW + 1;
  localparam int RhoSumW  = RHO_W + $clog2(MaxHistory);
  localparam int ThSumW   = THETA_W + $clog2(MaxHistory);
  localparam int DepthRst = (DEPTH_RESET > MaxHistory) ? MaxHistory : DEPTH_RESET;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM,
    ST_UPD,
    ST_DSTART,
    ST_DWAIT
  } state_e;

  state_e                     state_q, state_d;
  cmd_t                       cmd_q;
  logic [CntW-1:0]            depth_q;
  logic [CntW-1:0]            cnt_q     [2];
  logic [CntW-1:0]            cnt_d     [2];
  logic [IdxW-1:0]            oldest_q  [2];
  logic [IdxW-1:0]            oldest_d  [2];
  logic signed [RhoSumW-1:0]  rho_sum_q [2];
  logic signed [RhoSumW-1:0]  rho_sum_d [2];
  logic [ThSumW-1:0]          th_sum_q  [2];
  logic [ThSumW-1:0]          th_sum_d  [2];

  logic [ENTRY_W-1:0]         rdata     [2];
  logic                       ring_we   [2];
  logic [IdxW-1:0]            ring_waddr[2];
  logic [ENTRY_W-1:0]         ring_wdata;

  logic [RhoSumW-1:0]         rho_mag   [2];
  logic [RhoSumW-1:0]         rho_quo   [2];
  logic [ThSumW-1:0]          th_quo    [2];
  logic [3:0]                 div_busy;
  logic                       div_start;

  logic                       trim_need;
  logic                       apply;
  logic                       out_load;
  logic                       out_valid_q;
  logic [OUT_DATA_W-1:0]      out_data_q, out_data_d;
  logic [1:0]                 out_user_q, out_user_d;
  logic [CntW-1:0]            depth_wr;

  assign ring_wdata = {cmd_q.theta, cmd_q.rho};

  // history rings, read port always on the oldest entry
  for (genvar s = 0; s < 2; s++) begin : g_ring
    llhs_ram #(
      .Width (ENTRY_W),
      .Depth (MaxHistory)
    ) u_ring (
      .clk_i   (clk_i),
      .we_i    (ring_we[s]),
      .waddr_i (ring_waddr[s]),
      .wdata_i (ring_wdata),
      .raddr_i (oldest_q[s]),
      .rdata_o (rdata[s])
    );
  end

  // averaging dividers, one per sum
  for (genvar s = 0; s < 2; s++) begin : g_div
    assign rho_mag[s] = rho_sum_q[s][RhoSumW-1] ? RhoSumW'(-rho_sum_q[s])
                                                : RhoSumW'(rho_sum_q[s]);

    llhs_div #(
      .DividendW (RhoSumW),
      .DivisorW  (CntW)
    ) u_div_rho (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (rho_mag[s]),
      .divisor_i  (cnt_q[s]),
      .busy_o     (div_busy[2*s]),
      .quotient_o (rho_quo[s])
    );

    llhs_div #(
      .DividendW (ThSumW),
      .DivisorW  (CntW)
    ) u_div_theta (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (th_sum_q[s]),
      .divisor_i  (cnt_q[s]),
      .busy_o     (div_busy[2*s+1]),
      .quotient_o (th_quo[s])
    );
  end

  assign trim_need = (cnt_q[SIDE_LEFT] > depth_q) || (cnt_q[SIDE_RIGHT] > depth_q);
  assign apply     = (state_q == ST_UPD) || (state_q == ST_TRIM);
  assign cmd_pop_o = (state_q == ST_IDLE) && !trim_need && cmd_valid_i;
  assign div_start = (state_q == ST_DSTART);
  assign out_load  = (state_q == ST_DWAIT) && (div_busy == '0) &&
                     (!out_valid_q || m_axis_tready);

  // per side drop of the oldest entry and push of the new line
  always_comb begin
    logic                      drop, push;
    logic [CntW-1:0]           kept;
    logic [IdxW-1:0]           old1;
    logic [SlotW-1:0]          slot;
    logic signed [RHO_W-1:0]   rd_rho;
    logic [THETA_W-1:0]        rd_th;
    logic signed [RhoSumW-1:0] rsum;
    logic [ThSumW-1:0]         tsum;
    for (int s = 0; s < 2; s++) begin
      rd_rho = rdata[s][RHO_W-1:0];
      rd_th  = rdata[s][RHO_W +: THETA_W];
      push   = (state_q == ST_UPD) && cmd_q.push[s];
      drop   = 1'b0;
      if (state_q == ST_UPD) begin
        drop = cmd_q.drop[s] ? (cnt_q[s] != '0) : (push && (cnt_q[s] == depth_q));
      end else if (state_q == ST_TRIM) begin
        drop = (cnt_q[s] > depth_q);
      end

      kept = cnt_q[s] - CntW'(drop);
      old1 = oldest_q[s];
      rsum = rho_sum_q[s];
      tsum = th_sum_q[s];
      if (drop) begin
        old1 = (oldest_q[s] == IdxW'(MaxHistory - 1)) ? '0 : oldest_q[s] + 1'b1;
        rsum = rsum - RhoSumW'(rd_rho);
        tsum = tsum - ThSumW'(rd_th);
      end
      if (push) begin
        rsum = rsum + RhoSumW'(cmd_q.rho);
        tsum = tsum + ThSumW'(cmd_q.theta);
      end

      // free slot behind the kept entries, wrapped once
      slot = SlotW'(old1) + SlotW'(kept);
      if (slot >= SlotW'(MaxHistory)) begin
        slot = slot - SlotW'(MaxHistory);
      end

      ring_we[s]    = push;
      ring_waddr[s] = slot[IdxW-1:0];
      cnt_d[s]      = apply ? kept + CntW'(push) : cnt_q[s];
      oldest_d[s]   = apply ? old1 : oldest_q[s];
      rho_sum_d[s]  = apply ? rsum : rho_sum_q[s];
      th_sum_d[s]   = apply ? tsum : th_sum_q[s];
    end
  end

  // result beat: empty sides report zeros
  always_comb begin
    logic [RhoSumW-1:0] rq;
    logic               vld;
    out_data_d = '0;
    out_user_d = '0;
    for (int s = 0; s < 2; s++) begin
      vld = (cnt_q[s] != '0);
      rq  = rho_sum_q[s][RhoSumW-1] ? RhoSumW'(-rho_quo[s]) : rho_quo[s];
      out_user_d[s] = vld;
      if (vld) begin
        out_data_d[s*ENTRY_W +: RHO_W]           = rq[RHO_W-1:0];
        out_data_d[s*ENTRY_W + RHO_W +: THETA_W] = th_quo[s][THETA_W-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (trim_need) begin
          state_d = ST_TRIM;
        end else if (cmd_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_TRIM:   state_d = ST_IDLE;
      ST_UPD:    state_d = cmd_q.frame_end ? ST_DSTART : ST_IDLE;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // clamp the written depth into 1..MaxHistory
  always_comb begin
    if (cfg_wdata_i == '0) begin
      depth_wr = CntW'(1);
    end else if (32'(cfg_wdata_i) > 32'(MaxHistory)) begin
      depth_wr = CntW'(MaxHistory);
    end else begin
      depth_wr = CntW'(cfg_wdata_i);
    end
  end

  // state, history bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= CntW'(DepthRst);
      out_valid_q <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        cnt_q[s]     <= '0;
        oldest_q[s]  <= '0;
        rho_sum_q[s] <= '0;
        th_sum_q[s]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        depth_q <= depth_wr;
      end
      for (int s = 0; s < 2; s++) begin
        cnt_q[s]     <= cnt_d[s];
        oldest_q[s]  <= oldest_d[s];
        rho_sum_q[s] <= rho_sum_d[s];
        th_sum_q[s]  <= th_sum_d[s];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- design/lane_line_history_smoother.sv -----
// ----------------------------------------------------------------------------
// lane_line_history_smoother
// Keeps a short history of the left and right lane line per frame and
// reports their averaged rho and theta at every frame end.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one detected line each (tdata: rho, theta; tuser: line
//   present), in vote order; tlast closes the frame. Only the frame-end beat
//   produces an output beat: left and right average rho and theta, with the
//   valid flags of both sides in tuser.
//   Input beats go through a four-entry command queue, so the input side
//   keeps accepting while the history logic works or the output waits.
//   The history logic handles each beat as a read of the oldest ring entry,
//   then the update. A frame-end beat then starts the bit-serial averaging
//   dividers and waits for them to finish before its result is loaded into
//   the output register. A history_depth write below the current fill
//   drops the oldest entries before the next beat is processed.
//   Reset empties both histories and sets the depth to 10; the rings need no
//   clearing pass. When the receiver stalls, the result stays in the output
//   register and the next frame-end beat waits for it to be taken.
// ----------------------------------------------------------------------------
module lane_line_history_smoother #(
  parameter int MaxHistory = llhs_pkg::MAX_HISTORY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: history_depth
  input  logic                            cfg_we_i,
  input  logic [llhs_pkg::DEPTH_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [llhs_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // line_rho, line_theta, pad
  input  logic                            s_axis_tlast,  // frame_end
  input  logic                            s_axis_tuser,  // has_line
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // left_rho_avg, left_theta_avg, right_rho_avg, right_theta_avg, pad
  output logic [llhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                      m_axis_tuser   // left_valid, right_valid
);
  import llhs_pkg::*;

  logic cmd_push, queue_full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;

  llhs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full_i  (queue_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  llhs_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (queue_full),
    .pop_i       (cmd_pop),
    .valid_o     (cmd_valid),
    .pop_data_o  (cmd_out)
  );

  llhs_back #(
    .MaxHistory (MaxHistory)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- design/llhs_checker.sv -----
// ----------------------------------------------------------------------------
// llhs_checker
// Port-level checks on the smoother's output beats, bound to the top level.
// ----------------------------------------------------------------------------
module llhs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [llhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);
  import llhs_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // empty left side reports zeros
  a_left_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[ENTRY_W-1:0] == '0)
    else $error("empty left side with nonzero averages");

  // empty right side reports zeros
  a_right_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[2*ENTRY_W-1:ENTRY_W] == '0)
    else $error("empty right side with nonzero averages");

  // average of left angles stays in the left window
  a_left_theta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[ENTRY_W-1:RHO_W] <= THETA_LEFT_MAX)
    else $error("left average angle outside left window");

  // average of right angles stays in the right window
  a_right_theta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[2*ENTRY_W-1:ENTRY_W+RHO_W] >= THETA_RIGHT_MIN) &&
      (m_axis_tdata[2*ENTRY_W-1:ENTRY_W+RHO_W] <= THETA_PI))
    else $error("right average angle outside right window");

endmodule

bind lane_line_history_smoother llhs_checker u_llhs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/lane_line_history_checker.sv -----
// ----------------------------------------------------------------------------
// lane_line_history_checker
// Watches both streams and the depth register of the lane line history
// smoother. It keeps its own left/right history rings, forecasts the
// averages that each frame-end beat must produce, and compares every output
// beat field by field against the oldest forecast.
// ----------------------------------------------------------------------------
module lane_line_history_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [llhs_pkg::DEPTH_W-1:0]    cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [llhs_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // line_rho, line_theta, pad
  input  logic                            s_axis_tlast,   // frame_end
  input  logic                            s_axis_tuser,   // has_line
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // left_rho_avg, left_theta_avg, right_rho_avg, right_theta_avg, pad
  input  logic [llhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]                      m_axis_tuser,   // left_valid, right_valid
  output int                              results_owed_o,
  output int                              fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import llhs_pkg::*;

  typedef struct packed {
    logic                    valid;
    logic signed [RHO_W-1:0] rho;
    logic [THETA_W-1:0]      theta;
  } side_avg_t;

  typedef struct packed {
    side_avg_t right_avg;
    side_avg_t left_avg;
  } lane_avg_t;

  // Shadow history, one ring per side
  logic signed [RHO_W-1:0] ring_rho   [2][MAX_HISTORY];
  logic [THETA_W-1:0]      ring_theta [2][MAX_HISTORY];
  int                      fill       [2];
  int                      oldest     [2];
  int                      rho_sum    [2];
  int                      angle_sum  [2];
  bit                      found      [2];
  int                      depth;
  int                      errs;
  lane_avg_t               avg_due_q  [$];

  function automatic void drop_oldest(int s);
    if (fill[s] == 0) return;
    rho_sum[s]   -= ring_rho[s][oldest[s]];
    angle_sum[s] -= int'(ring_theta[s][oldest[s]]);
    oldest[s]     = (oldest[s] + 1) % MAX_HISTORY;
    fill[s]--;
  endfunction

  function automatic void push_line(int s, logic signed [RHO_W-1:0] rho,
                                    logic [THETA_W-1:0] theta);
    int slot;
    while (fill[s] >= depth) drop_oldest(s);
    slot = (oldest[s] + fill[s]) % MAX_HISTORY;
    ring_rho[s][slot]   = rho;
    ring_theta[s][slot] = theta;
    rho_sum[s]   += rho;
    angle_sum[s] += int'(theta);
    fill[s]++;
    found[s] = 1'b1;
  endfunction

  // Empty side reports zeros; division truncates toward zero
  function automatic side_avg_t side_average(int s);
    side_avg_t a;
    a = '0;
    if (fill[s] != 0) begin
      a.valid = 1'b1;
      a.rho   = RHO_W'(rho_sum[s] / fill[s]);
      a.theta = THETA_W'(angle_sum[s] / fill[s]);
    end
    return a;
  endfunction

  // Depth writes clamp to 1..MAX_HISTORY; shrinking keeps the newest lines
  function automatic void set_depth(logic [DEPTH_W-1:0] d);
    depth = int'(d);
    if (depth == 0) depth = 1;
    if (depth > MAX_HISTORY) depth = MAX_HISTORY;
    for (int s = SIDE_LEFT; s <= SIDE_RIGHT; s++) begin
      while (fill[s] > depth) drop_oldest(s);
    end
  endfunction

  function automatic void take_line(logic has, logic signed [RHO_W-1:0] rho,
                                    logic [THETA_W-1:0] theta, logic last);
    lane_avg_t a;
    if (has) begin
      if (!found[SIDE_LEFT] && theta <= THETA_LEFT_MAX) begin
        push_line(SIDE_LEFT, rho, theta);
      end else if (!found[SIDE_RIGHT] && theta >= THETA_RIGHT_MIN &&
                   theta <= THETA_PI) begin
        push_line(SIDE_RIGHT, rho, theta);
      end
    end
    if (!last) return;
    // Frame close: a side without a line this frame ages out one entry
    for (int s = SIDE_LEFT; s <= SIDE_RIGHT; s++) begin
      if (!found[s]) drop_oldest(s);
      found[s] = 1'b0;
    end
    a.left_avg  = side_average(SIDE_LEFT);
    a.right_avg = side_average(SIDE_RIGHT);
    avg_due_q.insert(avg_due_q.size(), a);
  endfunction

  function automatic void compare_field(string what, int due, int got);
    if (due == got) return;
    errs++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, due, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lane_avg_t due;
    lane_avg_t got;
    if (!rst_ni) begin
      for (int s = SIDE_LEFT; s <= SIDE_RIGHT; s++) begin
        fill[s]      = 0;
        oldest[s]    = 0;
        rho_sum[s]   = 0;
        angle_sum[s] = 0;
        found[s]     = 1'b0;
      end
      depth = DEPTH_RESET;
      errs  = 0;
      avg_due_q.delete();
      results_owed_o <= 0;
      fail_count_o   <= 0;
    end else begin
      // Output beat against the oldest forecast
      if (m_axis_tvalid && m_axis_tready) begin
        got.left_avg.valid  = m_axis_tuser[0];
        got.left_avg.rho    = m_axis_tdata[RHO_W-1:0];
        got.left_avg.theta  = m_axis_tdata[RHO_W +: THETA_W];
        got.right_avg.valid = m_axis_tuser[1];
        got.right_avg.rho   = m_axis_tdata[ENTRY_W +: RHO_W];
        got.right_avg.theta = m_axis_tdata[ENTRY_W+RHO_W +: THETA_W];
        if (avg_due_q.size() == 0) begin
          errs++;
          $display("%0t ns: unexpected result beat, expected none, actual %h / %b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          due = avg_due_q[0];
          avg_due_q.delete(0);
          compare_field("left_valid", due.left_avg.valid, got.left_avg.valid);
          compare_field("left_rho_avg", due.left_avg.rho, got.left_avg.rho);
          compare_field("left_theta_avg", due.left_avg.theta, got.left_avg.theta);
          compare_field("right_valid", due.right_avg.valid, got.right_avg.valid);
          compare_field("right_rho_avg", due.right_avg.rho, got.right_avg.rho);
          compare_field("right_theta_avg", due.right_avg.theta, got.right_avg.theta);
        end
      end
      if (cfg_we_i) set_depth(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready)
        take_line(s_axis_tuser, s_axis_tdata[RHO_W-1:0], s_axis_tdata[RHO_W +: THETA_W],
                  s_axis_tlast);
      results_owed_o <= avg_due_q.size();
      fail_count_o   <= errs;
    end
  end

endmodule

// ----- tb/lane_line_history_smoother_tb.sv -----
// ----------------------------------------------------------------------------
// lane_line_history_smoother_tb
// Drives frames of detected lines into the smoother: a directed set for the
// angle windows, empty sides and rounding, then random frames under several
// history depths with sender gaps and receiver stalls. A separate checker
// forecasts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
module lane_line_history_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import llhs_pkg::*;

  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int BEATS_PER_LEG  = 158;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [DEPTH_W-1:0]    cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // line_rho, line_theta, pad
  logic                  s_axis_tlast  = 1'b0;  // frame_end
  logic                  s_axis_tuser  = 1'b0;  // has_line
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // left rho/theta avg, right rho/theta avg, pad
  logic [1:0]            m_axis_tuser;   // left_valid, right_valid

  int results_owed;
  int fail_count;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int quiet_cycles  = 0;

  lane_line_history_smoother u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lane_line_history_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .results_owed_o (results_owed),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog: too long without any beat on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles at %0t ns", quiet_cycles, $time);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat; returns in the step of its acceptance with tvalid held
  task automatic send_beat(input logic has, input logic [RHO_W-1:0] rho,
                           input logic [THETA_W-1:0] theta, input logic last);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {{(IN_DATA_W-ENTRY_W){1'b0}}, theta, rho};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending and wait until every frame result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] d);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [RHO_W-1:0] pick_rho();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return RHO_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly lane windows, some dead band and out-of-range angles
  function automatic logic [THETA_W-1:0] pick_theta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return THETA_W'($urandom_range(0, THETA_LEFT_MAX));
    if (r < 80) return THETA_W'($urandom_range(THETA_RIGHT_MIN, THETA_PI));
    if (r < 90) return THETA_W'($urandom_range(THETA_LEFT_MAX + 1, THETA_RIGHT_MIN - 1));
    return THETA_W'($urandom_range(0, 32767));
  endfunction

  // One frame: a few lines, stray noise beats, then the closing beat
  task automatic send_frame(inout int beats);
    int n_lines;
    n_lines = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(0, 4);
    repeat (n_lines) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(1'b0, pick_rho(), THETA_W'($urandom_range(0, 32767)), 1'b0);
        beats++;
      end
      send_beat(1'b1, pick_rho(), pick_theta(), 1'b0);
      beats++;
    end
    if ($urandom_range(0, 1) != 0)
      send_beat(1'b1, pick_rho(), pick_theta(), 1'b1);
    else
      send_beat(1'b0, pick_rho(), THETA_W'($urandom_range(0, 32767)), 1'b1);
    beats++;
  endtask

  function automatic logic [DEPTH_W-1:0] depth_for_leg(int leg);
    case (leg)
      0:       return 5'd0;    // acts as 1
      1:       return 5'd31;   // acts as 16
      2:       return 5'd16;
      3:       return 5'd3;    // shrinks a full history
      4:       return 5'd1;
      default: return 5'd17;
    endcase
  endfunction

  initial begin : stimulus
    int  beats;
    bit  paused;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of rho and theta on both sides
    send_beat(1'b1, 16'h8000, 15'd0, 1'b0);
    send_beat(1'b1, 16'h7fff, THETA_PI, 1'b1);
    // Window edges, ignored angles, second left line, empty closing beat
    send_beat(1'b1, 16'd100, THETA_LEFT_MAX, 1'b0);
    send_beat(1'b1, 16'd5, THETA_LEFT_MAX + 15'd1, 1'b0);
    send_beat(1'b1, 16'd7, THETA_RIGHT_MIN - 15'd1, 1'b0);
    send_beat(1'b1, 16'hfffb, THETA_PI + 15'd1, 1'b0);
    send_beat(1'b1, 16'd9, 15'h7fff, 1'b0);
    send_beat(1'b1, 16'hffff, THETA_RIGHT_MIN, 1'b0);
    send_beat(1'b1, 16'd3, 15'd100, 1'b0);
    send_beat(1'b0, 16'h5555, 15'h2aaa, 1'b1);
    // Frame without lines: both sides age
    send_beat(1'b0, 16'haaaa, 15'h5555, 1'b0);
    send_beat(1'b0, 16'h0000, 15'd0, 1'b1);
    // Line on the closing beat
    send_beat(1'b1, 16'd16, THETA_PI, 1'b1);
    // Age both sides down to empty
    repeat (3) send_beat(1'b0, 16'h0000, 15'd0, 1'b1);
    // Negative average rounds toward zero
    send_beat(1'b1, 16'hfffd, 15'd1, 1'b1);
    send_beat(1'b1, 16'hfffc, 15'd2, 1'b1);

    // Random legs under changing depth and idling
    for (int leg = 0; leg < 6; leg++) begin
      case (leg / 2)
        0:       begin src_idle_pct = 14; snk_stall_pct = 56; end
        1:       begin src_idle_pct = 56; snk_stall_pct = 14; end
        default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      endcase
      write_depth(depth_for_leg(leg));
      beats = 0;
      while (beats < BEATS_PER_LEG) begin
        send_frame(beats);
        if (leg == 1 && !paused && beats >= BEATS_PER_LEG / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/llhs_pkg.sv
design/llhs_ram.sv
design/llhs_div.sv
design/llhs_fifo.sv
design/llhs_front.sv
design/llhs_back.sv
design/lane_line_history_smoother.sv
design/llhs_checker.sv
tb/lane_line_history_checker.sv
tb/lane_line_history_smoother_tb.sv
